// ===== hdl/tfcd_pkg.sv =====
// Shared types, constants and the CRC16 byte update for the telemetry frame checker.
package tfcd_pkg;

   // Frame geometry
   localparam logic [3:0] BASE_LEN    = 4'd9;
   localparam logic [3:0] TS_LEN      = 4'd13;
   localparam logic [3:0] STORE_DEPTH = 4'd11;
   localparam logic [3:0] COUNT_MAX   = 4'd15;

   // CRC16 CCITT polynomial, MSB first
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Register reset values
   localparam logic [3:0]  EXPECTED_VERSION_RST = 4'd0;
   localparam logic [15:0] CRC_INIT_RST         = 16'hFFFF;
   localparam logic [7:0]  TS_FLAG_MASK_RST     = 8'h01;
   localparam logic [3:0]  HIGHEST_TYPE_RST     = 4'd5;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_TOO_SHORT    = 3'd1,
      STATUS_BAD_LENGTH   = 3'd2,
      STATUS_BAD_CRC      = 3'd3,
      STATUS_UNKNOWN_TYPE = 3'd4,
      STATUS_BAD_VERSION  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_EXPECTED_VERSION = 2'd0,
      REG_CRC_INIT         = 2'd1,
      REG_TS_FLAG_MASK     = 2'd2,
      REG_HIGHEST_TYPE     = 2'd3
   } reg_index_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  version;
      logic [3:0]  frame_type;
      logic [15:0] node_id;
      logic [7:0]  sequence_res;
      logic [9:0]  station;
      logic [3:0]  speed;
      logic [7:0]  flag_bits;
      logic        has_timestamp;
      logic [31:0] timestamp;
   } result_type;

   // One byte through the CRC16, eight shift steps
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_val,
                                              input logic [7:0]  data_val);
      logic [15:0] acc;
      acc = crc_val ^ {data_val, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// ===== hdl/tfcd_out_buffer.sv =====
// Result register with a skid entry between the frame logic and the result channel.
module tfcd_out_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tfcd_pkg::result_type  in_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output tfcd_pkg::result_type  out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   tfcd_pkg::result_type out_data_ff, out_data_in;
   tfcd_pkg::result_type skid_data_ff, skid_data_in;
   logic                 out_take;

   assign out_take = out_valid_ff & ~out_stall;

   // Beat routing: skid drains first, new results go to the output or the skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== hdl/telemetry_frame_checker_decoder.sv =====
// Top level: byte-wise CRC16 frame checker and field decoder.
// Accepts one frame byte per cycle while not stalled; no gaps between frames.
// A frame's result is registered in the output buffer, then shown on rsp_.
// The byte CRC update is combinational; a skid entry holds one
// extra result, and input stalls only while that entry is occupied.
// Synchronous active-high reset clears counters, handshake state, config regs.
module telemetry_frame_checker_decoder (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_is_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_version,
   output logic [3:0]  rsp_frame_type,
   output logic [15:0] rsp_node_id,
   output logic [7:0]  rsp_sequence_res,
   output logic [9:0]  rsp_station,
   output logic [3:0]  rsp_speed,
   output logic [7:0]  rsp_flag_bits,
   output logic        rsp_has_timestamp,
   output logic [31:0] rsp_timestamp,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // configuration registers
   logic [3:0]  expected_version_ff;
   logic [15:0] crc_init_ff;
   logic [7:0]  ts_flag_mask_ff;
   logic [3:0]  highest_type_ff;

   // frame state
   logic [3:0]  byte_count_ff, byte_count_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] tail_pair_ff, tail_pair_in;
   logic [7:0]  header_ff [11];

   logic                 req_accept;
   logic                 buf_full;
   logic [15:0]          crc_base;
   logic                 ts;
   logic [3:0]           expect_len;
   logic [15:0]          station_word;
   tfcd_pkg::status_type status;
   tfcd_pkg::result_type result;

   assign req_stall  = buf_full;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= tfcd_pkg::EXPECTED_VERSION_RST;
         crc_init_ff         <= tfcd_pkg::CRC_INIT_RST;
         ts_flag_mask_ff     <= tfcd_pkg::TS_FLAG_MASK_RST;
         highest_type_ff     <= tfcd_pkg::HIGHEST_TYPE_RST;
      end else if (csr_valid && csr_ready) begin
         case (tfcd_pkg::reg_index_type'(csr_index))
            tfcd_pkg::REG_EXPECTED_VERSION: expected_version_ff <= csr_data[3:0];
            tfcd_pkg::REG_CRC_INIT:         crc_init_ff         <= csr_data;
            tfcd_pkg::REG_TS_FLAG_MASK:     ts_flag_mask_ff     <= csr_data[7:0];
            tfcd_pkg::REG_HIGHEST_TYPE:     highest_type_ff     <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // per-byte state update: CRC trails the input by two bytes
   always_comb begin
      crc_base = (byte_count_ff == 4'd0) ? crc_init_ff : running_crc_ff;
      if (byte_count_ff >= 4'd2) begin
         running_crc_in = tfcd_pkg::crc16_byte(crc_base, tail_pair_ff[15:8]);
      end else begin
         running_crc_in = crc_base;
      end
      tail_pair_in  = {tail_pair_ff[7:0], req_frame_byte};
      byte_count_in = (byte_count_ff == tfcd_pkg::COUNT_MAX) ? byte_count_ff
                                                             : byte_count_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         running_crc_ff <= tfcd_pkg::CRC_INIT_RST;
         tail_pair_ff   <= '0;
      end else if (req_accept) begin
         if (req_is_last) begin
            byte_count_ff  <= '0;
            running_crc_ff <= crc_init_ff;
            tail_pair_ff   <= '0;
         end else begin
            byte_count_ff  <= byte_count_in;
            running_crc_ff <= running_crc_in;
            tail_pair_ff   <= tail_pair_in;
         end
      end
   end

   // header bytes, written once per frame position
   always_ff @(posedge clock) begin
      if (req_accept && (byte_count_ff < tfcd_pkg::STORE_DEPTH)) begin
         header_ff[byte_count_ff] <= req_frame_byte;
      end
   end

   // verdict in priority order
   always_comb begin
      ts         = (header_ff[6] & ts_flag_mask_ff) != 8'd0;
      expect_len = ts ? tfcd_pkg::TS_LEN : tfcd_pkg::BASE_LEN;
      if (byte_count_in < tfcd_pkg::BASE_LEN) begin
         status = tfcd_pkg::STATUS_TOO_SHORT;
      end else if (byte_count_in != expect_len) begin
         status = tfcd_pkg::STATUS_BAD_LENGTH;
      end else if (running_crc_in != tail_pair_in) begin
         status = tfcd_pkg::STATUS_BAD_CRC;
      end else if (header_ff[0][3:0] > highest_type_ff) begin
         status = tfcd_pkg::STATUS_UNKNOWN_TYPE;
      end else if ((expected_version_ff != 4'd0) &&
                   (header_ff[0][7:4] != expected_version_ff)) begin
         status = tfcd_pkg::STATUS_BAD_VERSION;
      end else begin
         status = tfcd_pkg::STATUS_OK;
      end
   end

   // field unpacking, zeroed on any error
   always_comb begin
      station_word = {header_ff[4], header_ff[5]};
      result        = '0;
      result.status = status;
      if (status == tfcd_pkg::STATUS_OK) begin
         result.version       = header_ff[0][7:4];
         result.frame_type    = header_ff[0][3:0];
         result.node_id       = {header_ff[1], header_ff[2]};
         result.sequence_res  = header_ff[3];
         result.station       = station_word[15:6];
         result.speed         = station_word[5:2];
         result.flag_bits     = header_ff[6];
         result.has_timestamp = ts;
         if (ts) begin
            result.timestamp = {header_ff[7], header_ff[8], header_ff[9], header_ff[10]};
         end
      end
   end

   tfcd_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept & req_is_last),
      .in_data   (result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  ({rsp_status, rsp_version, rsp_frame_type, rsp_node_id,
                   rsp_sequence_res, rsp_station, rsp_speed, rsp_flag_bits,
                   rsp_has_timestamp, rsp_timestamp})
   );

endmodule
